/* src/clipped_palette_sprite_blit_unit_defines.svh */
// Assertion macros shared by the sprite blitter modules.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef CLIPPED_PALETTE_SPRITE_BLIT_UNIT_DEFINES_SVH
`define CLIPPED_PALETTE_SPRITE_BLIT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CPSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cpsb_pkg.sv */
`default_nettype none
package cpsb_pkg;

  // Fixed field widths.
  localparam int IDX_W      = 8;
  localparam int PIX_W      = 16;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int ADDR_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Largest image dimension.
  localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

  // RGB555 blend masks.
  localparam logic [PIX_W-1:0] HALF_MASK = 16'h3DEF;
  localparam logic [PIX_W-1:0] QTR_MASK  = 16'h1CE7;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND      = 3'd5;

  // Per-item state handed from the clip stage to the output stage.
  typedef struct packed {
    logic               draw;
    logic               last;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [PIX_W-1:0]   dest_old;
  } s1_t;

  // 75 percent new color plus 25 percent old color, per RGB555 channel.
  function automatic logic [PIX_W-1:0] blend_75_25(input logic [PIX_W-1:0] new_c,
                                                   input logic [PIX_W-1:0] old_c);
    logic [PIX_W-1:0] half;
    half = (new_c >> 1) & HALF_MASK;
    return ((old_c >> 2) & QTR_MASK) + half + ((half >> 1) & QTR_MASK);
  endfunction

endpackage
`default_nettype wire

/* src/cpsb_if.sv */
`default_nettype none
// Input channel: palette loads and source pixels.
interface cpsb_in_if import cpsb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] color_index;
  logic [PIX_W-1:0] pal_value;
  logic [PIX_W-1:0] dest_old;

  modport source (output valid, kind, color_index, pal_value, dest_old, input ready);
  modport sink   (input valid, kind, color_index, pal_value, dest_old, output ready);
endinterface

// Result channel: frame-buffer writes.
interface cpsb_out_if import cpsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [ADDR_W-1:0] fb_address;
  logic [PIX_W-1:0]  pixel_value;
  logic              last_pixel;

  modport source (output valid, write_enable, fb_address, pixel_value, last_pixel,
                  input ready);
  modport sink   (input valid, write_enable, fb_address, pixel_value, last_pixel,
                  output ready);
endinterface
`default_nettype wire

/* src/cpsb_out_stage.sv */
`default_nettype none
`include "clipped_palette_sprite_blit_unit_defines.svh"
module cpsb_out_stage import cpsb_pkg::*; #(
  parameter int SCREEN_WIDTH     = 320,
  parameter int LINE_TABLE_WORDS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       blend_mode,
  input  wire logic       s1_valid,
  input  wire s1_t        s1,
  input  wire logic [PIX_W-1:0] pal_color,
  output logic            s1_ready,
  cpsb_out_if.source      out_item
);

  localparam int SW_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int SUM_W = COORD_W + SW_W + 2;

  logic              out_valid_r, out_valid_nxt;
  logic              we_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PIX_W-1:0]  value_r;
  logic              last_r;
  logic              take;
  logic [SUM_W-1:0]  addr_full;
  logic [PIX_W-1:0]  color;

  // The result register may be refilled when empty or when being drained.
  assign s1_ready = !out_valid_r || out_item.ready;
  assign take     = s1_valid && s1_ready;

  // Address: line table offset plus row times pitch plus column.
  assign addr_full = SUM_W'(LINE_TABLE_WORDS)
                   + SUM_W'(s1.sy) * SUM_W'(SCREEN_WIDTH)
                   + SUM_W'(s1.sx);

  // Opaque copy or 75/25 blend with the old word.
  assign color = blend_mode ? blend_75_25(pal_color, s1.dest_old) : pal_color;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; skipped pixels and loads give zero address and value.
  always_ff @(posedge clk) begin
    if (take) begin
      we_r    <= s1.draw;
      addr_r  <= s1.draw ? addr_full[ADDR_W-1:0] : '0;
      value_r <= s1.draw ? color : '0;
      last_r  <= s1.last;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.write_enable = we_r;
  assign out_item.fb_address   = addr_r;
  assign out_item.pixel_value  = value_r;
  assign out_item.last_pixel   = last_r;

  `CPSB_ASSERT_NOW(a_skip_zero, out_valid_r && !we_r, addr_r == '0 && value_r == '0, "skipped item carries data")
  `CPSB_ASSERT_NEXT(a_nodraw_nowe, take && !s1.draw, !we_r, "write enable on a skipped item")
  `CPSB_ASSERT_NEXT(a_last_kept, take && s1.last, last_r && out_valid_r, "last mark lost")

endmodule
`default_nettype wire

/* src/clipped_palette_sprite_blit_unit.sv */
// Channel | Dir | Payload                                         | Handshake
// in_item | in  | kind, color_index, pal_value, dest_old           | valid/ready
// out_item| out | write_enable, fb_address, pixel_value, last_pixel| valid/ready
// cfg_*   | in  | cfg_index, cfg_data                             | cfg_we, no wait
//
// One item is accepted per clock while in_item.ready is high; each result is registered
// first in the palette read and clip registers, which feed the address multiply and
// blend, then in the result register.
// Synchronous active-low reset clears both counters and all valid bits, sets the image size
// config to 1 and clears the rest of it; the palette is undefined until loaded.
// in_item.ready falls only while both pipeline registers are full and out_item stalls.
`default_nettype none
`include "clipped_palette_sprite_blit_unit_defines.svh"
module clipped_palette_sprite_blit_unit import cpsb_pkg::*; #(
  parameter int SCREEN_WIDTH     = 320,
  parameter int SCREEN_HEIGHT    = 224,
  parameter int LINE_TABLE_WORDS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cpsb_in_if.sink                    in_item,
  cpsb_out_if.source                 out_item
);

  // Configuration registers.
  logic [DIM_W-1:0] pos_x_r, pos_y_r, img_w_r, img_h_r;
  logic [IDX_W-1:0] transp_r;
  logic             blend_r;

  // Image position counters.
  logic [COORD_W-1:0] col_r, col_nxt, row_r, row_nxt;

  // Clip stage register and palette memory.
  logic             s1_valid_r, s1_valid_nxt;
  s1_t              s1_r, s1_nxt;
  logic [PIX_W-1:0] pal_mem [0:(1 << IDX_W)-1];
  logic [PIX_W-1:0] pal_rd_r;

  logic               s1_ready, in_fire, is_pixel;
  logic signed [DIM_W:0] sx_full, sy_full;
  logic               vis_x, vis_y;
  logic [DIM_W-1:0]   w_eff, h_eff, col_inc, row_inc;
  logic               col_end, row_end;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      img_w_r  <= DIM_W'(1);
      img_h_r  <= DIM_W'(1);
      transp_r <= '0;
      blend_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:      pos_x_r  <= cfg_data;
        REG_POS_Y:      pos_y_r  <= cfg_data;
        REG_IMG_WIDTH:  img_w_r  <= cfg_data;
        REG_IMG_HEIGHT: img_h_r  <= cfg_data;
        REG_TRANSP:     transp_r <= cfg_data[IDX_W-1:0];
        REG_BLEND:      blend_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.ready = !s1_valid_r || s1_ready;
  assign in_fire       = in_item.valid && in_item.ready;
  assign is_pixel      = in_item.kind == KIND_PIXEL;

  // Screen position of the current pixel and the clip test.
  assign sx_full = $signed({pos_x_r[DIM_W-1], pos_x_r}) + $signed({2'b00, col_r});
  assign sy_full = $signed({pos_y_r[DIM_W-1], pos_y_r}) + $signed({2'b00, row_r});
  assign vis_x   = !sx_full[DIM_W] && (sx_full[DIM_W-1:0] < DIM_W'(SCREEN_WIDTH));
  assign vis_y   = !sy_full[DIM_W] && (sy_full[DIM_W-1:0] < DIM_W'(SCREEN_HEIGHT));

  // Image dimensions clamped to 1..1024.
  assign w_eff = (img_w_r == '0) ? DIM_W'(1) : ((img_w_r > DIM_MAX) ? DIM_MAX : img_w_r);
  assign h_eff = (img_h_r == '0) ? DIM_W'(1) : ((img_h_r > DIM_MAX) ? DIM_MAX : img_h_r);
  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);
  assign col_end = col_inc >= w_eff;
  assign row_end = row_inc >= h_eff;

  // Raster counters advance on pixels only.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire && is_pixel) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_nxt = col_inc[COORD_W-1:0];
      end
    end
  end

  // Clip stage payload.
  always_comb begin
    s1_nxt.draw     = is_pixel && vis_x && vis_y && (in_item.color_index != transp_r);
    s1_nxt.last     = is_pixel && col_end && row_end;
    s1_nxt.sx       = sx_full[COORD_W-1:0];
    s1_nxt.sy       = sy_full[COORD_W-1:0];
    s1_nxt.dest_old = in_item.dest_old;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // Palette memory: written by loads, read by every accepted item.
  always_ff @(posedge clk) begin
    if (in_fire && !is_pixel) begin
      pal_mem[in_item.color_index] <= in_item.pal_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pal_rd_r <= pal_mem[in_item.color_index];
    end
  end

  // Address, color and result register.
  cpsb_out_stage #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .LINE_TABLE_WORDS (LINE_TABLE_WORDS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .blend_mode (blend_r),
    .s1_valid   (s1_valid_r),
    .s1         (s1_r),
    .pal_color  (pal_rd_r),
    .s1_ready   (s1_ready),
    .out_item   (out_item)
  );

  `CPSB_ASSERT_NEXT(a_load_holds_pos, in_fire && !is_pixel, $stable(col_r) && $stable(row_r), "palette load moved the counters")
  `CPSB_ASSERT_NEXT(a_wrap_at_last, in_fire && s1_nxt.last, col_r == '0 && row_r == '0, "counters not cleared after last pixel")
  `CPSB_ASSERT_NOW(a_draw_on_screen, s1_valid_r && s1_r.draw, s1_r.sx < COORD_W'(SCREEN_WIDTH - 1) || s1_r.sx == COORD_W'(SCREEN_WIDTH - 1), "drawn pixel off screen")

endmodule
`default_nettype wire
